// ===== rtl/core/srtfd_pkg.sv =====
package srtfd_pkg;

  // Port widths of the beats
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = 16;
  localparam int REM_W      = 16;
  localparam int STATUS_W   = 2;

  // Default fraction width N of the divisor
  localparam int DIVISOR_BITS_DEF = 16;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // Sequencer states of the iterative unit
  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_FIX,
    S_DONE
  } srtfd_state_t;

  // Control and status from the iterative unit to the top level
  typedef struct packed {
    logic    idle;
    logic    done;
    status_t status;
  } srtfd_ctl_t;

endpackage

// ===== rtl/core/srtfd_core.sv =====
module srtfd_core #(
  parameter int DIVISOR_BITS = srtfd_pkg::DIVISOR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [2*DIVISOR_BITS-1:0] num,
  input  logic [DIVISOR_BITS-1:0]   den,
  input  logic                      ack,
  output srtfd_pkg::srtfd_ctl_t     ctl,
  output logic [DIVISOR_BITS-1:0]   quot,
  output logic [DIVISOR_BITS-1:0]   rem
);
  import srtfd_pkg::*;

  localparam int N  = DIVISOR_BITS;
  localparam int PW = N + 3;               // signed partial remainder width
  localparam int CW = (N > 1) ? $clog2(N) : 1;

  srtfd_state_t   state_r, state_nxt;
  logic [PW-1:0]  p_r, p_nxt;              // partial remainder, two's complement
  logic [N-1:0]   lo_r, lo_nxt;            // dividend bits still to shift in
  logic [N-1:0]   d_r, d_nxt;
  logic [N-1:0]   q_r, q_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  status_t        st_r, st_nxt;

  // Shared adder: one add or subtract of the divisor per cycle
  logic [PW-1:0]  add_a;
  logic [PW-1:0]  add_b;
  logic           add_sub;
  logic [PW-1:0]  add_sum;
  logic [PW-1:0]  d_ext;

  assign d_ext   = {3'b000, d_r};
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(PW-1){1'b0}}, add_sub};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    lo_r  <= lo_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    st_r  <= st_nxt;
  end

  // Sequencer: load, N non-restoring steps, final correction, hold result (errors go straight to hold)
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    d_nxt     = d_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    add_a     = p_r;
    add_b     = d_ext;
    add_sub   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          d_nxt   = den;
          lo_nxt  = num[N-1:0];
          p_nxt   = {3'b000, num[2*N-1:N]};
          q_nxt   = '0;
          cnt_nxt = CW'(N - 1);
          if (den == '0) begin
            st_nxt    = ST_DIV0;
            p_nxt     = '0;
            state_nxt = S_DONE;
          end else if (num[2*N-1:N] >= den) begin
            st_nxt    = ST_OVF;
            p_nxt     = '0;
            state_nxt = S_DONE;
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_ITER;
          end
        end
      end
      S_ITER: begin
        // 2P + next bit, then subtract D if P was non-negative, else add D
        add_a   = {p_r[PW-2:0], lo_r[N-1]};
        add_sub = ~p_r[PW-1];
        p_nxt   = add_sum;
        lo_nxt  = {lo_r[N-2:0], 1'b0};
        q_nxt   = {q_r[N-2:0], ~add_sum[PW-1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        // negative last remainder: add the divisor back
        add_b     = p_r[PW-1] ? d_ext : '0;
        p_nxt     = add_sum;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctl.idle   = (state_r == S_IDLE);
  assign ctl.done   = (state_r == S_DONE);
  assign ctl.status = st_r;
  assign quot       = q_r;
  assign rem        = p_r[N-1:0];

endmodule

// ===== rtl/core/srt_fraction_divider.sv =====
// Fractional divider, non-restoring radix-2 with final remainder correction.
// A valid division passes through load, N iteration steps, correction and the result
// register; a zero divisor or an overflow goes from load straight to the result register.
// The sequencer, with its single shared adder, takes a new beat only once the last result has left it.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, synchronous) clears the sequencer and the result valid flag.
module srt_fraction_divider #(
  parameter int DIVISOR_BITS = srtfd_pkg::DIVISOR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srtfd_pkg::DIVIDEND_W-1:0]    in_dividend,
  input  logic [srtfd_pkg::DIVISOR_W-1:0]     in_divisor_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srtfd_pkg::QUOT_W-1:0]        out_quotient,
  output logic [srtfd_pkg::REM_W-1:0]         out_remainder,
  output logic [srtfd_pkg::STATUS_W-1:0]      out_status
);
  import srtfd_pkg::*;

  localparam int N = DIVISOR_BITS;

  logic [2*N-1:0] num;
  logic [N-1:0]   den;
  logic [N-1:0]   quot;
  logic [N-1:0]   rem;
  logic [QUOT_W-1:0] quot_w;
  logic [REM_W-1:0]  rem_w;
  srtfd_ctl_t     ctl;
  logic           start;
  logic           ack;

  logic                out_valid_r, out_valid_nxt;
  logic [QUOT_W-1:0]   out_quotient_r;
  logic [REM_W-1:0]    out_remainder_r;
  logic [STATUS_W-1:0] out_status_r;

  // Fit the beat fields to the N-bit datapath
  if (2 * N <= DIVIDEND_W) begin : g_num_cut
    assign num = in_dividend[2*N-1:0];
  end else begin : g_num_ext
    assign num = {{(2*N-DIVIDEND_W){1'b0}}, in_dividend};
  end

  if (N <= DIVISOR_W) begin : g_den_cut
    assign den = in_divisor_value[N-1:0];
  end else begin : g_den_ext
    assign den = {{(N-DIVISOR_W){1'b0}}, in_divisor_value};
  end

  if (N >= QUOT_W) begin : g_q_cut
    assign quot_w = quot[QUOT_W-1:0];
  end else begin : g_q_ext
    assign quot_w = {{(QUOT_W-N){1'b0}}, quot};
  end

  if (N >= REM_W) begin : g_r_cut
    assign rem_w = rem[REM_W-1:0];
  end else begin : g_r_ext
    assign rem_w = {{(REM_W-N){1'b0}}, rem};
  end

  // Input side
  assign in_stall = ~ctl.idle;
  assign start    = in_valid & ~in_stall;

  srtfd_core #(
    .DIVISOR_BITS (DIVISOR_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num),
    .den   (den),
    .ack   (ack),
    .ctl   (ctl),
    .quot  (quot),
    .rem   (rem)
  );

  // Output register: load when empty or being drained
  assign ack = ctl.done & (~out_valid_r | ~out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ack) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_quotient_r  <= quot_w;
      out_remainder_r <= rem_w;
      out_status_r    <= ctl.status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quotient  = out_quotient_r;
  assign out_remainder = out_remainder_r;
  assign out_status    = out_status_r;

endmodule

// ===== rtl/core/srtfd_checker.sv =====
module srtfd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [srtfd_pkg::QUOT_W-1:0]        out_quotient,
  input logic [srtfd_pkg::REM_W-1:0]         out_remainder,
  input logic [srtfd_pkg::STATUS_W-1:0]      out_status
);
  import srtfd_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quotient)
      && $stable(out_remainder) && $stable(out_status))
    else $error("stalled result beat changed");

  // Error results carry zero quotient and remainder
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DIV0 || out_status == ST_OVF)
      |-> out_quotient == '0 && out_remainder == '0)
    else $error("error result with non-zero payload");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_DIV0 || out_status == ST_OVF)
    else $error("undefined status code");

  // An accepted input beat makes the unit busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a division is running");

endmodule

bind srt_fraction_divider srtfd_checker u_srtfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_quotient  (out_quotient),
  .out_remainder (out_remainder),
  .out_status    (out_status)
);

// ===== dv/division_checker.sv =====
// Watches both channels of the fractional divider, works out each quotient
// from the input beat and compares it with the result beats in order.
module division_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [srtfd_pkg::DIVIDEND_W-1:0] in_dividend,
  input  logic [srtfd_pkg::DIVISOR_W-1:0]  in_divisor_value,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [srtfd_pkg::QUOT_W-1:0]     out_quotient,
  input  logic [srtfd_pkg::REM_W-1:0]      out_remainder,
  input  logic [srtfd_pkg::STATUS_W-1:0]   out_status,
  output int                               fail_count,
  output int                               pending
);
  import srtfd_pkg::*;

  localparam int N = DIVISOR_BITS_DEF;

  typedef struct packed {
    logic [QUOT_W-1:0] quotient;
    logic [REM_W-1:0]  remainder;
    status_t           status;
  } division_t;

  division_t quotients_due[$];
  division_t want;

  // Exact fractional division; zero divisor and too-large high half give no quotient
  function automatic division_t divide_fraction(input logic [DIVIDEND_W-1:0] dividend,
                                                input logic [DIVISOR_W-1:0]  divisor);
    division_t             res;
    logic [DIVIDEND_W-1:0] den_full;
    logic [DIVIDEND_W-1:0] q_full;
    logic [DIVIDEND_W-1:0] r_full;
    den_full      = {{(DIVIDEND_W-DIVISOR_W){1'b0}}, divisor};
    res.quotient  = '0;
    res.remainder = '0;
    res.status    = ST_OK;
    if (divisor == '0) begin
      res.status = ST_DIV0;
    end else if (dividend[2*N-1 -: N] >= divisor) begin
      res.status = ST_OVF;
    end else begin
      q_full        = dividend / den_full;
      r_full        = dividend - q_full * den_full;
      res.quotient  = q_full[QUOT_W-1:0];
      res.remainder = r_full[REM_W-1:0];
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (expected !== actual) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Result beat is checked before the input beat of the same edge is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (quotients_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual %h %h %h",
                   $time, out_quotient, out_remainder, out_status);
        end else begin
          want = quotients_due.pop_front();
          compare_field("quotient", 32'(want.quotient), 32'(out_quotient));
          compare_field("remainder", 32'(want.remainder), 32'(out_remainder));
          compare_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (in_valid && !in_stall)
        quotients_due = {quotients_due, divide_fraction(in_dividend, in_divisor_value)};
    end
    pending = quotients_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import srtfd_pkg::*;

  localparam int RANDOM_BEATS     = 650;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 40;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic [DIVIDEND_W-1:0] in_dividend      = '0;
  logic [DIVISOR_W-1:0]  in_divisor_value = '0;
  logic                  out_stall        = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [QUOT_W-1:0]     out_quotient;
  logic [REM_W-1:0]      out_remainder;
  logic [STATUS_W-1:0]   out_status;

  int fail_count;
  int pending;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  srt_fraction_divider u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dividend      (in_dividend),
    .in_divisor_value (in_divisor_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_quotient     (out_quotient),
    .out_remainder    (out_remainder),
    .out_status       (out_status)
  );

  division_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dividend      (in_dividend),
    .in_divisor_value (in_divisor_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_quotient     (out_quotient),
    .out_remainder    (out_remainder),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always #1 clk = ~clk;

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random hold-off per result, or one long hold on request
  initial begin
    int wait_cycles;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (out_valid === 1'b1) begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 5);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(negedge clk);
          out_stall <= 1'b0;
        end
        @(posedge clk);
      end
    end
  end

  // Offer one division beat after a random gap and hold it until taken
  task automatic offer_division(input logic [DIVIDEND_W-1:0] dividend,
                                input logic [DIVISOR_W-1:0]  divisor);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_dividend      <= dividend;
    in_divisor_value <= divisor;
    do @(posedge clk); while (in_stall);
  endtask

  // Lower valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int                    kind;
    int                    width;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVISOR_W-1:0]  high_half;
    logic [31:0]           low_bits;
    logic [DIVIDEND_W-1:0] dividend;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero divisor, overflow edges, largest quotient, tiny divisors
    offer_division(32'h0000_0000, 16'h0000);
    offer_division(32'hFFFF_FFFF, 16'h0000);
    offer_division(32'h0000_0000, 16'h0001);
    offer_division(32'h0000_FFFF, 16'h0001);
    offer_division(32'h0001_0000, 16'h0001);
    offer_division(32'h8000_0000, 16'h8000);
    offer_division(32'h7FFF_FFFF, 16'h8000);
    offer_division(32'hFFFE_FFFF, 16'hFFFF);
    offer_division(32'hFFFF_0000, 16'hFFFF);
    offer_division(32'hFFFF_FFFF, 16'hFFFF);
    offer_division(32'h0000_0001, 16'hFFFF);
    offer_division(32'h0001_2345, 16'h0003);
    offer_division(32'h0002_FFFF, 16'h0003);
    offer_division(32'h0622_4E60, 16'h5678);
    offer_division(32'h5555_AAAA, 16'hAAAA);
    offer_division(32'h0000_0000, 16'hFFFF);
    drain_results();

    // Random: mostly in-range divisions over all divisor magnitudes
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      quiet = (i % 100) < 15;
      if (i == 200)
        long_hold_req = 1'b1;
      if (i == 300 || i == 550)
        drain_results();

      kind     = $urandom_range(0, 99);
      width    = $urandom_range(1, DIVISOR_W);
      divisor  = DIVISOR_W'($urandom & ((32'd1 << width) - 32'd1));
      low_bits = $urandom;
      if (kind < 85 && divisor == '0)
        divisor = 16'h0001;
      if (kind < 10)
        high_half = divisor - 16'd1;
      else if (kind < 70)
        high_half = DIVISOR_W'($urandom_range(0, divisor - 16'd1));
      else if (kind < 85)
        high_half = DIVISOR_W'($urandom_range(divisor, 16'hFFFF));
      else
        high_half = low_bits[31:16];
      dividend = {high_half, low_bits[15:0]};
      if (kind >= 85 && kind < 90)
        divisor = '0;
      else if (kind >= 90)
        divisor = DIVISOR_W'($urandom);
      offer_division(dividend, divisor);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
